// File: rtl/great_circle_distance_core_assert.svh
// Assertion macros shared by the distance core.
// Both sample on i_clk and are off while i_rst_n is low.
`ifndef GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`define GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define GCD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("gcd assertion failed");

// implication after a fixed number of cycles
`define GCD_ASSERT_DELAY(label, ante, n, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> ##(n) (cons)) \
        else $error("gcd delayed assertion failed");

`endif

// File: rtl/gcd_pkg.sv
package gcd_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int DW           = 64;
    localparam int RATIO_BITS   = 38;
    localparam int QW           = RATIO_BITS + 1;
    localparam int OUT_W        = 25;
    localparam int UNIT_W       = 33;
    localparam int TURN_W       = 30;
    localparam int SCALE_LAT    = RATIO_BITS + 3;

    typedef logic signed [DW-1:0] t_word;
    typedef logic [DW-1:0]        t_uword;
    typedef logic signed [31:0]   t_mas;
    typedef t_word                t_atan_tab [CORDIC_STEPS];

    localparam t_uword ONE_Q61 = 64'h2000_0000_0000_0000;
    localparam logic [31:0] MAS_FULL_TURN = 32'd1296000000;
    localparam logic [31:0] MAS_HALF_TURN = 32'd648000000;
    localparam logic [OUT_W-1:0] HALF_CIRC_M = 25'd20001600;

    // truncating unsigned long division, shift and subtract; series terms only
    function automatic t_uword series_div(input t_uword num, input t_uword den);
        t_uword quo;
        t_uword rem;
        quo = '0;
        rem = '0;
        for (int b = DW - 1; b >= 0; b--) begin
            rem = {rem[DW-2:0], num[b]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // arctan(1/5) by its series, Q2.61, truncating terms
    function automatic t_uword atan_inv5();
        t_uword term;
        t_uword sum;
        t_uword t;
        t_uword k;
        logic   sub;
        term = ONE_Q61 / 5;
        sum  = term;
        k    = 1;
        sub  = 1'b1;
        term = term / 5 / 5;
        while (term != 0) begin
            t    = series_div(term, 2 * k + 1);
            sum  = sub ? sum - t : sum + t;
            sub  = ~sub;
            k    = k + 1;
            term = term / 5 / 5;
        end
        return sum;
    endfunction

    function automatic t_uword atan_inv239();
        t_uword term;
        t_uword sum;
        t_uword t;
        t_uword k;
        logic   sub;
        term = ONE_Q61 / 239;
        sum  = term;
        k    = 1;
        sub  = 1'b1;
        term = term / 239 / 239;
        while (term != 0) begin
            t    = series_div(term, 2 * k + 1);
            sum  = sub ? sum - t : sum + t;
            sub  = ~sub;
            k    = k + 1;
            term = term / 239 / 239;
        end
        return sum;
    endfunction

    // arctan(2^-i), i >= 1
    function automatic t_uword atan_inv_pow2(input int i);
        t_uword term;
        t_uword sum;
        t_uword t;
        t_uword k;
        logic   sub;
        term = ONE_Q61 >> i;
        sum  = term;
        k    = 1;
        sub  = 1'b1;
        term = term >> (2 * i);
        while (term != 0) begin
            t    = series_div(term, 2 * k + 1);
            sum  = sub ? sum - t : sum + t;
            sub  = ~sub;
            k    = k + 1;
            term = term >> (2 * i);
        end
        return sum;
    endfunction

    // Machin
    localparam t_uword PI_Q61  = 4 * (4 * atan_inv5() - atan_inv239());
    localparam t_uword HALF_PI = PI_Q61 / 2;

    // mas to Q2.61 radians of the half angle: integer part and 32-bit fraction
    localparam t_uword UNIT_FULL = PI_Q61 / MAS_FULL_TURN;
    localparam t_uword FRAC_FULL = ((PI_Q61 % MAS_FULL_TURN) << 32) / MAS_FULL_TURN;
    localparam logic [UNIT_W-1:0] UNIT_C = UNIT_FULL[UNIT_W-1:0];
    localparam logic [31:0]       FRAC_C = FRAC_FULL[31:0];

    function automatic t_word atan_entry(input int i);
        if (i == 0) begin
            return t_word'(PI_Q61 / 4);
        end
        return t_word'(atan_inv_pow2(i));
    endfunction

    function automatic t_atan_tab build_atan();
        t_atan_tab tab;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            tab[i] = atan_entry(i);
        end
        return tab;
    endfunction

    localparam t_atan_tab ATAN_ROM = build_atan();

endpackage

// File: rtl/gcd_half_angle.sv
// cos and sin (gain-scaled magnitudes) of half an angle given in mas
module gcd_half_angle (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gcd_pkg::t_mas  i_angle,
    output logic           o_valid,
    output gcd_pkg::t_uword o_cos,
    output gcd_pkg::t_uword o_sin
);
    import gcd_pkg::*;

    logic [31:0]        r_mag;
    logic [TURN_W-1:0]  r_a;
    logic [62:0]        r_ph;
    logic [61:0]        r_pl;
    logic               r_v1, r_v2, r_v3, r_vo;
    logic               r_v [CORDIC_STEPS+1];
    t_word              r_x [CORDIC_STEPS+1];
    t_word              r_y [CORDIC_STEPS+1];
    t_word              r_z [CORDIC_STEPS+1];
    t_uword             r_cos, r_sin;

    logic [31:0]        n_red, n_fold;

    always_comb begin
        n_red  = (r_mag >= MAS_FULL_TURN) ? r_mag - MAS_FULL_TURN : r_mag;
        n_fold = (n_red > MAS_HALF_TURN) ? MAS_FULL_TURN - n_red : n_red;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_vo <= 1'b0;
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v[0] <= r_v3;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_v[i+1] <= r_v[i];
            end
            r_vo <= r_v[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= i_angle[31] ? 32'(-i_angle) : 32'(i_angle);
        r_a   <= n_fold[TURN_W-1:0];
        r_ph  <= {33'b0, r_a} * {30'b0, UNIT_C};
        r_pl  <= {32'b0, r_a} * {30'b0, FRAC_C};
        r_x[0] <= t_word'(ONE_Q61);
        r_y[0] <= '0;
        r_z[0] <= t_word'({1'b0, r_ph} + {34'b0, r_pl[61:32]});
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (r_z[i] >= 0) begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ATAN_ROM[i];
            end else begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ATAN_ROM[i];
            end
        end
        r_cos <= r_x[CORDIC_STEPS][DW-1] ? t_uword'(-r_x[CORDIC_STEPS])
                                         : t_uword'(r_x[CORDIC_STEPS]);
        r_sin <= r_y[CORDIC_STEPS][DW-1] ? t_uword'(-r_y[CORDIC_STEPS])
                                         : t_uword'(r_y[CORDIC_STEPS]);
    end

    assign o_valid = r_vo;
    assign o_cos   = r_cos;
    assign o_sin   = r_sin;

endmodule

// File: rtl/gcd_mul_quarter.sv
// (a*b) >> 63 from four registered 32x32 partial products
module gcd_mul_quarter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  gcd_pkg::t_uword i_a,
    input  gcd_pkg::t_uword i_b,
    output logic            o_valid,
    output gcd_pkg::t_uword o_p
);
    import gcd_pkg::*;

    logic [63:0]  r_ll, r_lh, r_hl, r_hh;
    logic         r_v1, r_v2;
    t_uword       r_p;
    logic [127:0] n_full;

    always_comb begin
        n_full = {64'b0, r_ll} + {32'b0, r_lh, 32'b0} + {32'b0, r_hl, 32'b0} + {r_hh, 64'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ll <= {32'b0, i_a[31:0]}  * {32'b0, i_b[31:0]};
        r_lh <= {32'b0, i_a[31:0]}  * {32'b0, i_b[63:32]};
        r_hl <= {32'b0, i_a[63:32]} * {32'b0, i_b[31:0]};
        r_hh <= {32'b0, i_a[63:32]} * {32'b0, i_b[63:32]};
        r_p  <= n_full[126:63];
    end

    assign o_valid = r_v2;
    assign o_p     = r_p;

endmodule

// File: rtl/gcd_vector.sv
// vectoring CORDIC, one step per stage: magnitude (gain-scaled) and angle
module gcd_vector (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  gcd_pkg::t_word i_x,
    input  gcd_pkg::t_word i_y,
    output logic           o_valid,
    output gcd_pkg::t_word o_mag,
    output gcd_pkg::t_word o_ang
);
    import gcd_pkg::*;

    logic  r_v [CORDIC_STEPS+1];
    t_word r_x [CORDIC_STEPS+1];
    t_word r_y [CORDIC_STEPS+1];
    t_word r_z [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= CORDIC_STEPS; i++) begin
                r_v[i] <= 1'b0;
            end
        end else begin
            r_v[0] <= i_valid;
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                r_v[i+1] <= r_v[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= i_x;
        r_y[0] <= i_y;
        r_z[0] <= '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (r_y[i] >= 0) begin
                r_x[i+1] <= r_x[i] + (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] - (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] + ATAN_ROM[i];
            end else begin
                r_x[i+1] <= r_x[i] - (r_y[i] >>> i);
                r_y[i+1] <= r_y[i] + (r_x[i] >>> i);
                r_z[i+1] <= r_z[i] - ATAN_ROM[i];
            end
        end
    end

    assign o_valid = r_v[CORDIC_STEPS];
    assign o_mag   = r_x[CORDIC_STEPS];
    assign o_ang   = r_z[CORDIC_STEPS];

endmodule

// File: rtl/gcd_scale.sv
// angle / (pi/2) by restoring division, one quotient bit per stage,
// then times half the circumference, rounded half up
module gcd_scale (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  gcd_pkg::t_word            i_ang,
    output logic                      o_valid,
    output logic [gcd_pkg::OUT_W-1:0] o_dist
);
    import gcd_pkg::*;

    logic                  r_v   [RATIO_BITS+1];
    logic                  r_sat [RATIO_BITS+1];
    t_uword                r_rem [RATIO_BITS+1];
    logic [RATIO_BITS-1:0] r_q   [RATIO_BITS+1];
    logic                  r_vm, r_vo;
    logic [QW-33+OUT_W:0]  r_ph;
    logic [32+OUT_W-1:0]   r_pl;
    logic [OUT_W-1:0]      r_dist;

    t_uword                n_theta;
    t_uword                n_rem2 [RATIO_BITS];
    logic                  n_bit  [RATIO_BITS];
    logic [QW-1:0]         n_q;
    logic [63:0]           n_total;

    always_comb begin
        n_theta = i_ang[DW-1] ? '0 : t_uword'(i_ang);
        for (int i = 0; i < RATIO_BITS; i++) begin
            n_rem2[i] = r_rem[i] << 1;
            n_bit[i]  = n_rem2[i] >= HALF_PI;
        end
        n_q = r_sat[RATIO_BITS] ? QW'(1) << RATIO_BITS : {1'b0, r_q[RATIO_BITS]};
        n_total = {r_ph[31:0], 32'b0} + {7'b0, r_pl} + (64'd1 << (RATIO_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= RATIO_BITS; i++) begin
                r_v[i] <= 1'b0;
            end
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
            for (int i = 0; i < RATIO_BITS; i++) begin
                r_v[i+1] <= r_v[i];
            end
            r_vm <= r_v[RATIO_BITS];
            r_vo <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0] <= n_theta;
        r_sat[0] <= n_theta >= HALF_PI;
        r_q[0]   <= '0;
        for (int i = 0; i < RATIO_BITS; i++) begin
            r_rem[i+1] <= n_bit[i] ? n_rem2[i] - HALF_PI : n_rem2[i];
            r_q[i+1]   <= {r_q[i][RATIO_BITS-2:0], n_bit[i]};
            r_sat[i+1] <= r_sat[i];
        end
        r_ph   <= {25'b0, n_q[QW-1:32]} * {7'b0, HALF_CIRC_M};
        r_pl   <= {25'b0, n_q[31:0]} * {32'b0, HALF_CIRC_M};
        r_dist <= n_total[RATIO_BITS+OUT_W-1:RATIO_BITS];
    end

    assign o_valid = r_vo;
    assign o_dist  = r_dist;

endmodule

// File: rtl/great_circle_distance_core.sv
// Great-circle distance core (haversine central angle, whole meters).
//
// Input: pulse start with the two points on i_first_latitude,
// i_first_longitude, i_second_latitude and i_second_longitude (signed
// milliarcseconds). A word is taken at every clock edge where start is high
// and busy is low; busy is always low, so one word per cycle is accepted.
// Output: o_distance_meters, valid for exactly one cycle while o_valid is
// high. The receiver cannot hold results off and none is needed: results
// leave in acceptance order at the accept rate.
// Path from start to o_valid: the input register, the half-angle rotation
// CORDIC, the quarter multipliers, two vectoring CORDIC passes, then the
// 38-stage quotient pipeline against pi/2 and its output multiply.
// Throughput: one word per cycle.
// Reset (i_rst_n low, synchronous) clears all valid bits; words in flight
// are dropped, datapath registers keep whatever they hold.
// Out-of-range coordinates are taken modulo a full turn; the result
// always lies in 0 .. 20001600.
`include "great_circle_distance_core_assert.svh"

module great_circle_distance_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic signed [29:0]          i_first_latitude,
    input  logic signed [30:0]          i_first_longitude,
    input  logic signed [29:0]          i_second_latitude,
    input  logic signed [30:0]          i_second_longitude,
    output logic                        o_valid,
    output logic [gcd_pkg::OUT_W-1:0]   o_distance_meters
);
    import gcd_pkg::*;

    // front: angle differences and latitude sum
    logic  r_v0;
    t_mas  r_dl, r_dn, r_sm;

    // half-angle trig
    logic   v_trig;
    t_uword c_dl, s_dl, c_dn, s_dn, c_s, s_s;

    // products of the haversine terms
    logic   v_prod;
    t_uword p_hx, p_hy, p_cx, p_cy;

    // the two hypotenuses, then the final angle
    logic   v_vec_h, v_vec_c, v_ang;
    t_word  mag_h, mag_c, ang;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else begin
            r_v0 <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl <= t_mas'(i_first_latitude) - t_mas'(i_second_latitude);
        r_dn <= t_mas'(i_first_longitude) - t_mas'(i_second_longitude);
        r_sm <= t_mas'(i_first_latitude) + t_mas'(i_second_latitude);
    end

    gcd_half_angle u_trig_dl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_dl),
        .o_valid(v_trig), .o_cos(c_dl), .o_sin(s_dl)
    );
    gcd_half_angle u_trig_dn (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_dn),
        .o_valid(), .o_cos(c_dn), .o_sin(s_dn)
    );
    gcd_half_angle u_trig_sm (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(r_v0), .i_angle(r_sm),
        .o_valid(), .o_cos(c_s), .o_sin(s_s)
    );

    // sin(dl/2)cos(dn/2), cos(s/2)sin(dn/2), cos(dl/2)cos(dn/2), sin(s/2)sin(dn/2)
    gcd_mul_quarter u_mul_hx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_trig), .i_a(s_dl), .i_b(c_dn),
        .o_valid(v_prod), .o_p(p_hx)
    );
    gcd_mul_quarter u_mul_hy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_trig), .i_a(c_s), .i_b(s_dn),
        .o_valid(), .o_p(p_hy)
    );
    gcd_mul_quarter u_mul_cx (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_trig), .i_a(c_dl), .i_b(c_dn),
        .o_valid(), .o_p(p_cx)
    );
    gcd_mul_quarter u_mul_cy (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_trig), .i_a(s_s), .i_b(s_dn),
        .o_valid(), .o_p(p_cy)
    );

    gcd_vector u_vec_h (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_prod),
        .i_x(t_word'(p_hx)), .i_y(t_word'(p_hy)),
        .o_valid(v_vec_h), .o_mag(mag_h), .o_ang()
    );
    gcd_vector u_vec_c (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_prod),
        .i_x(t_word'(p_cx)), .i_y(t_word'(p_cy)),
        .o_valid(v_vec_c), .o_mag(mag_c), .o_ang()
    );

    // half central angle = atan2(hypot_h, hypot_c); CORDIC gains cancel
    gcd_vector u_vec_ang (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_vec_h),
        .i_x(mag_c), .i_y(mag_h),
        .o_valid(v_ang), .o_mag(), .o_ang(ang)
    );

    gcd_scale u_scale (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(v_ang), .i_ang(ang),
        .o_valid(o_valid), .o_dist(o_distance_meters)
    );

    `GCD_ASSERT_IMPLY(a_dist_range, o_valid, o_distance_meters <= HALF_CIRC_M)
    `GCD_ASSERT_IMPLY(a_hyp_lockstep, v_vec_h, v_vec_c)
    `GCD_ASSERT_IMPLY(a_cos_lockstep, v_vec_c, v_vec_h)
    `GCD_ASSERT_DELAY(a_scale_latency, v_ang, SCALE_LAT, o_valid)

endmodule

// File: bench/great_circle_distance_core_tb.sv
module great_circle_distance_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gcd_pkg::*;

    localparam int  LATENCY   = 3 * CORDIC_STEPS + 51;
    localparam int  LAT_SPAN  = 324000000;   // 90 deg in mas
    localparam int  LON_SPAN  = 648000000;   // 180 deg in mas
    localparam longint unsigned HALF_CIRC = 64'd20001600;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic signed [29:0]      i_first_latitude;
    logic signed [30:0]      i_first_longitude;
    logic signed [29:0]      i_second_latitude;
    logic signed [30:0]      i_second_longitude;
    logic                    o_valid;
    logic [OUT_W-1:0]        o_distance_meters;

    // expected distances, oldest first
    logic [OUT_W-1:0] pending_distances [$];
    int               error_count;
    int               words_sent;
    int               results_seen;
    int               idle_pct;

    great_circle_distance_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_first_latitude   (i_first_latitude),
        .i_first_longitude  (i_first_longitude),
        .i_second_latitude  (i_second_latitude),
        .i_second_longitude (i_second_longitude),
        .o_valid            (o_valid),
        .o_distance_meters  (o_distance_meters)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Distance predictor
    // ---------------------------------------------------------------

    // Q2.61 product, then divided by four: bits 126..63 of the full product
    function automatic t_uword mul_quarter(input t_uword a, input t_uword b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[126:63];
    endfunction

    function automatic t_uword abs64(input longint v);
        return (v < 0) ? t_uword'(-v) : t_uword'(v);
    endfunction

    // rotation CORDIC on half of the given angle; magnitudes of cos, sin
    task automatic half_angle_sin_cos(input longint mas_angle,
                                      output t_uword cos_mag, output t_uword sin_mag);
        t_uword a;
        longint x, y, z, dx, dy;
        a = abs64(mas_angle) % 64'(MAS_FULL_TURN);
        if (a > 64'(MAS_HALF_TURN)) begin
            a = 64'(MAS_FULL_TURN) - a;
        end
        z = longint'(a * UNIT_FULL + ((a * FRAC_FULL) >> 32));
        x = longint'(ONE_Q61);
        y = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx; y = y + dy; z = z - ATAN_ROM[i];
            end else begin
                x = x + dx; y = y - dy; z = z + ATAN_ROM[i];
            end
        end
        cos_mag = abs64(x);
        sin_mag = abs64(y);
    endtask

    task automatic vector_cordic(input longint xin, input longint yin,
                                 output longint mag, output longint ang);
        longint x, y, z, dx, dy;
        x = xin;
        y = yin;
        z = 0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x = x + dx; y = y - dy; z = z + ATAN_ROM[i];
            end else begin
                x = x - dx; y = y + dy; z = z - ATAN_ROM[i];
            end
        end
        mag = x;
        ang = z;
    endtask

    task automatic predict_distance(input logic signed [29:0] lat_a,
                                    input logic signed [30:0] lon_a,
                                    input logic signed [29:0] lat_b,
                                    input logic signed [30:0] lon_b,
                                    output logic [OUT_W-1:0] meters);
        t_uword c_dl, s_dl, c_dn, s_dn, c_s, s_s, theta, rem, q, prod;
        longint mag_h, mag_c, ang, spare;
        longint la1, lo1, la2, lo2;
        la1 = lat_a; lo1 = lon_a; la2 = lat_b; lo2 = lon_b;
        half_angle_sin_cos(la1 - la2, c_dl, s_dl);
        half_angle_sin_cos(lo1 - lo2, c_dn, s_dn);
        half_angle_sin_cos(la1 + la2, c_s, s_s);
        vector_cordic(longint'(mul_quarter(s_dl, c_dn)),
                      longint'(mul_quarter(c_s, s_dn)), mag_h, spare);
        vector_cordic(longint'(mul_quarter(c_dl, c_dn)),
                      longint'(mul_quarter(s_s, s_dn)), mag_c, spare);
        vector_cordic(mag_c, mag_h, spare, ang);
        // clamp to 0 .. pi/2, then ratio to pi/2 with RATIO_BITS fraction bits
        theta = (ang < 0) ? 64'd0 : t_uword'(ang);
        if (theta >= HALF_PI) begin
            q = t_uword'(1) << RATIO_BITS;
        end else begin
            rem = theta;
            q   = 0;
            for (int i = 0; i < RATIO_BITS; i++) begin
                rem = rem << 1;
                q   = q << 1;
                if (rem >= HALF_PI) begin
                    rem = rem - HALF_PI;
                    q   = q | 64'd1;
                end
            end
        end
        prod   = (q * HALF_CIRC + (t_uword'(1) << (RATIO_BITS - 1))) >> RATIO_BITS;
        meters = prod[OUT_W-1:0];
    endtask

    // ---------------------------------------------------------------
    // Driver: one word per call; start stays high across back-to-back words
    // ---------------------------------------------------------------
    task automatic send_points(input logic signed [29:0] lat_a,
                               input logic signed [30:0] lon_a,
                               input logic signed [29:0] lat_b,
                               input logic signed [30:0] lon_b);
        logic [OUT_W-1:0] expected;
        // random sender gap before this word
        while ($urandom_range(99, 0) < idle_pct) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start              <= 1'b1;
        i_first_latitude   <= lat_a;
        i_first_longitude  <= lon_a;
        i_second_latitude  <= lat_b;
        i_second_longitude <= lon_b;
        predict_distance(lat_a, lon_a, lat_b, lon_b, expected);
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_distances.push_back(expected);
        words_sent++;
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        $display("MISMATCH @%0t: %s", $realtime, what);
    endtask

    // Checker: results are sampled at the rising edge that ends their cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_distances.size() == 0) begin
                report_mismatch($sformatf("unexpected distance %0d", o_distance_meters));
            end else begin
                logic [OUT_W-1:0] want;
                want = pending_distances.pop_front();
                results_seen++;
                if (o_distance_meters !== want) begin
                    report_mismatch($sformatf("distance_meters got %0d want %0d",
                                              o_distance_meters, want));
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic signed [29:0] rand_lat();
        return 30'(int'($urandom_range(2 * LAT_SPAN, 0)) - LAT_SPAN);
    endfunction

    function automatic logic signed [30:0] rand_lon();
        return 31'(int'($urandom_range(2 * LON_SPAN, 0)) - LON_SPAN);
    endfunction

    // corners of the coordinate ranges, full-width extremes too
    task automatic test_extremes();
        send_points(30'sd0, 31'sd0, 30'sd0, 31'sd0);
        send_points(30'(LAT_SPAN), 31'sd0, 30'(-LAT_SPAN), 31'sd0);        // pole to pole
        send_points(30'sd0, 31'(LON_SPAN), 30'sd0, 31'(-LON_SPAN));        // same meridian
        send_points(30'sd0, 31'sd0, 30'sd0, 31'(LON_SPAN));                // antipodal on equator
        send_points(30'(LAT_SPAN), 31'(LON_SPAN), 30'(LAT_SPAN), 31'(-LON_SPAN));
        send_points(30'(-LAT_SPAN), 31'(-LON_SPAN), 30'(LAT_SPAN), 31'(LON_SPAN));
        // raw field extremes: out-of-range angles wrap modulo a full turn
        send_points({1'b0, {29{1'b1}}}, {1'b0, {30{1'b1}}},
                    {1'b1, {29{1'b0}}}, {1'b1, {30{1'b0}}});
        send_points({1'b1, {29{1'b0}}}, {1'b0, {30{1'b1}}},
                    {1'b0, {29{1'b1}}}, {1'b1, {30{1'b0}}});
        send_points(30'sd1, 31'sd1, 30'sd0, 31'sd0);
        send_points({30{1'b1}}, {31{1'b1}}, {30{1'b1}}, {31{1'b1}});
    endtask

    // near zero, near antipodal, and out-of-range coordinates
    task automatic test_special_cases();
        logic signed [29:0] la;
        logic signed [30:0] lo;
        for (int k = 0; k < 5; k++) begin
            la = rand_lat();
            lo = rand_lon();
            send_points(la, lo, la, lo);                            // identical points
            send_points(la, lo, 30'(la + $urandom_range(3, 1)), lo); // a few mas apart
            // antipode, nudged a little
            send_points(la, lo, -la,
                        31'((lo >= 0) ? lo - LON_SPAN + k : lo + LON_SPAN - k));
        end
        send_points(30'sd400000000, 31'sd0, 30'sd0, 31'sd700000000);
    endtask

    task automatic test_random(input int count, input int sender_idle);
        logic signed [29:0] la1, la2;
        logic signed [30:0] lo1, lo2;
        idle_pct = sender_idle;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9, 0))
                0: begin   // full-width noise, out of range allowed
                    la1 = 30'($urandom()); lo1 = 31'($urandom());
                    la2 = 30'($urandom()); lo2 = 31'($urandom());
                end
                1: begin   // short hop
                    la1 = rand_lat(); lo1 = rand_lon();
                    la2 = 30'(la1 + int'($urandom_range(2000, 0)) - 1000);
                    lo2 = 31'(lo1 + int'($urandom_range(2000, 0)) - 1000);
                end
                2: begin   // near antipodal
                    la1 = rand_lat(); lo1 = rand_lon();
                    la2 = 30'(-la1 + int'($urandom_range(2000, 0)) - 1000);
                    lo2 = 31'((lo1 >= 0) ? lo1 - LON_SPAN : lo1 + LON_SPAN);
                end
                default: begin
                    la1 = rand_lat(); lo1 = rand_lon();
                    la2 = rand_lat(); lo2 = rand_lon();
                end
            endcase
            send_points(la1, lo1, la2, lo2);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        int guard;
        error_count  = 0;
        words_sent   = 0;
        results_seen = 0;
        idle_pct     = 0;
        i_rst_n            = 1'b0;
        start              = 1'b0;
        i_first_latitude   = '0;
        i_first_longitude  = '0;
        i_second_latitude  = '0;
        i_second_longitude = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        idle_pct = 30;
        test_extremes();
        test_special_cases();
        test_random(650, 30);    // sender idles 30 in 100
        test_random(650, 73);    // then 73 in 100
        test_random(650, 0);     // then full rate
        @(negedge i_clk);
        start <= 1'b0;

        // drain: wait for every expected distance, bounded
        guard = 0;
        while (pending_distances.size() != 0 && guard < 20 * LATENCY) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 20) @(posedge i_clk);
        if (pending_distances.size() != 0) begin
            report_mismatch($sformatf("%0d distances never arrived",
                                      pending_distances.size()));
        end

        $display("Covered %0d point pairs (extremes, coincident, antipodal, wrapped, random)",
                 words_sent);
        $display("with sender gaps of 30%%, 73%% and none; %0d distances checked",
                 results_seen);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: great_circle_distance_core.f
+incdir+rtl
rtl/gcd_pkg.sv
rtl/gcd_half_angle.sv
rtl/gcd_mul_quarter.sv
rtl/gcd_vector.sv
rtl/gcd_scale.sv
rtl/great_circle_distance_core.sv
bench/great_circle_distance_core_tb.sv
